@@ sv/tvka_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the two-voice key assigner.
// Used by the top level and by the port checker; depends on nothing else.

package tvka_pkg;

   // Button and pattern geometry.
   localparam int NUM_BUTTONS = 8;
   localparam int PATTERN_LEN = 6;
   localparam int KEY_W       = $clog2(NUM_BUTTONS);
   localparam int CNT_W       = $clog2(NUM_BUTTONS + 1);
   localparam int HCNT_W      = $clog2(PATTERN_LEN + 1);

   // Octave limits.
   localparam logic [3:0] OCTAVE_MAX  = 4'd8;
   localparam logic [3:0] OCTAVE_MIN  = 4'd1;
   localparam logic [3:0] OCTAVE_BASE = 4'd4;

   // Gesture patterns, oldest press first.
   localparam logic [2:0] UP_PATTERN   [PATTERN_LEN] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0};
   localparam logic [2:0] DOWN_PATTERN [PATTERN_LEN] = '{3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd4};

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_APPEND,
      ST_MATCH,
      ST_READ0,
      ST_READ1,
      ST_EMIT
   } state_type;

   // Note class of a key: key modulo five, correct for keys below fifteen.
   function automatic logic [2:0] note_of(input logic [KEY_W-1:0] key);
      logic [4:0] kx;
      logic [4:0] r;
      kx = 5'(key);
      if (kx >= 5'd10) begin
         r = kx - 5'd10;
      end else if (kx >= 5'd5) begin
         r = kx - 5'd5;
      end else begin
         r = kx;
      end
      return r[2:0];
   endfunction

endpackage

@@ sv/two_voice_key_assigner_octave_gesture.sv @@
`timescale 1ns / 1ps
// Top level of the two-voice key assigner with octave gesture detection.
// Depends on tvka_pkg for geometry, patterns, states and the note function.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_buttons_now (8 bits)
//  rsp     | out       | rsp_valid/rsp_stall | voice0/voice1 active, key, note; octave_now
//
// A beat runs through scan capture, order-list compaction (skipped when no button is
// held), a walk over all buttons, the gesture match, two order-list reads and the
// response load. The order list is compacted one entry per cycle, and the button scan
// walks one button per cycle. reset is synchronous and active high; it clears the
// sequencer, the counts, the previous scan and sets the octave to four. A stalled
// response holds its beat; the sequencer waits in its final step until it can load.

module two_voice_key_assigner_octave_gesture
   import tvka_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_buttons_now,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_voice0_active,
   output logic [2:0] rsp_voice0_key,
   output logic [2:0] rsp_voice0_note,
   output logic       rsp_voice1_active,
   output logic [2:0] rsp_voice1_key,
   output logic [2:0] rsp_voice1_note,
   output logic [3:0] rsp_octave_now
);

   // Sequencer and control state.
   state_type               state_ff, state_in;
   logic [NUM_BUTTONS-1:0]  prev_ff, prev_in;
   logic [NUM_BUTTONS-1:0]  down_ff, down_in;
   logic [NUM_BUTTONS-1:0]  edge_ff, edge_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        wr_ff, wr_in;
   logic [CNT_W-1:0]        held_cnt_ff, held_cnt_in;
   logic [HCNT_W-1:0]       hist_cnt_ff, hist_cnt_in;
   logic [3:0]              octave_ff, octave_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [KEY_W-1:0]        order_ff [NUM_BUTTONS];
   logic [2:0]              hist_ff [PATTERN_LEN];
   logic [2:0]              hist_in [PATTERN_LEN];
   logic                    v0_act_ff, v0_act_in;
   logic [KEY_W-1:0]        v0_key_ff, v0_key_in;
   logic                    v1_act_ff, v1_act_in;
   logic [KEY_W-1:0]        v1_key_ff, v1_key_in;
   logic                    out_v0_act_ff, out_v0_act_in;
   logic [2:0]              out_v0_key_ff, out_v0_key_in;
   logic [2:0]              out_v0_note_ff, out_v0_note_in;
   logic                    out_v1_act_ff, out_v1_act_in;
   logic [2:0]              out_v1_key_ff, out_v1_key_in;
   logic [2:0]              out_v1_note_ff, out_v1_note_in;
   logic [3:0]              out_octave_ff, out_octave_in;

   // Order list access and combinational helpers.
   logic                    order_we;
   logic [KEY_W-1:0]        order_wa;
   logic [KEY_W-1:0]        order_wd;
   logic [KEY_W-1:0]        rd_idx;
   logic [KEY_W-1:0]        rd_key;
   logic [NUM_BUTTONS+7:0]  now_ext;
   logic [NUM_BUTTONS-1:0]  now_masked;
   logic                    up_hit;
   logic                    down_hit;

   // Buttons at or above NUM_BUTTONS are dropped.
   assign now_ext    = {NUM_BUTTONS'(0), req_buttons_now};
   assign now_masked = now_ext[NUM_BUTTONS-1:0];

   // The single read port of the order list.
   assign rd_key = order_ff[rd_idx];

   // Parallel compare of the history against both gestures.
   always_comb begin
      up_hit   = 1'b1;
      down_hit = 1'b1;
      for (int p = 0; p < PATTERN_LEN; p++) begin
         if (hist_ff[p] != UP_PATTERN[p]) begin
            up_hit = 1'b0;
         end
         if (hist_ff[p] != DOWN_PATTERN[p]) begin
            down_hit = 1'b0;
         end
      end
   end

   // Next state and datapath control.
   always_comb begin
      state_in       = state_ff;
      prev_in        = prev_ff;
      down_in        = down_ff;
      edge_in        = edge_ff;
      idx_in         = idx_ff;
      wr_in          = wr_ff;
      held_cnt_in    = held_cnt_ff;
      hist_cnt_in    = hist_cnt_ff;
      octave_in      = octave_ff;
      hist_in        = hist_ff;
      v0_act_in      = v0_act_ff;
      v0_key_in      = v0_key_ff;
      v1_act_in      = v1_act_ff;
      v1_key_in      = v1_key_ff;
      out_v0_act_in  = out_v0_act_ff;
      out_v0_key_in  = out_v0_key_ff;
      out_v0_note_in = out_v0_note_ff;
      out_v1_act_in  = out_v1_act_ff;
      out_v1_key_in  = out_v1_key_ff;
      out_v1_note_in = out_v1_note_ff;
      out_octave_in  = out_octave_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      order_we       = 1'b0;
      order_wa       = '0;
      order_wd       = '0;
      rd_idx         = idx_ff[KEY_W-1:0];
      req_stall      = 1'b1;

      case (state_ff)
         // Take a scan and find its press and release edges.
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               prev_in  = now_masked;
               down_in  = now_masked & ~prev_ff;
               edge_in  = now_masked ^ prev_ff;
               idx_in   = '0;
               wr_in    = '0;
               state_in = (held_cnt_ff == '0) ? ST_APPEND : ST_REMOVE;
            end
         end

         // Compact the order list, dropping every button with an edge.
         ST_REMOVE: begin
            rd_idx = idx_ff[KEY_W-1:0];
            if (!edge_ff[rd_key]) begin
               order_we = 1'b1;
               order_wa = wr_ff[KEY_W-1:0];
               order_wd = rd_key;
               wr_in    = wr_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == held_cnt_ff) begin
               held_cnt_in = edge_ff[rd_key] ? wr_ff : wr_ff + 1'b1;
               idx_in      = '0;
               state_in    = ST_APPEND;
            end
         end

         // Walk the buttons in ascending order and append each press.
         ST_APPEND: begin
            if (down_ff[idx_ff[KEY_W-1:0]]) begin
               if (held_cnt_ff < CNT_W'(NUM_BUTTONS)) begin
                  order_we    = 1'b1;
                  order_wa    = held_cnt_ff[KEY_W-1:0];
                  order_wd    = idx_ff[KEY_W-1:0];
                  held_cnt_in = held_cnt_ff + 1'b1;
               end
               for (int p = 0; p < PATTERN_LEN - 1; p++) begin
                  hist_in[p] = hist_ff[p+1];
               end
               hist_in[PATTERN_LEN-1] = idx_ff[2:0];
               if (hist_cnt_ff < HCNT_W'(PATTERN_LEN)) begin
                  hist_cnt_in = hist_cnt_ff + 1'b1;
               end
            end
            if (idx_ff == CNT_W'(NUM_BUTTONS - 1)) begin
               state_in = ST_MATCH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Step the octave on a completed gesture; up wins over down.
         ST_MATCH: begin
            if ((down_ff != '0) && (hist_cnt_ff == HCNT_W'(PATTERN_LEN))) begin
               if (up_hit) begin
                  if (octave_ff < OCTAVE_MAX) begin
                     octave_in = octave_ff + 4'd1;
                  end
               end else if (down_hit) begin
                  if (octave_ff > OCTAVE_MIN) begin
                     octave_in = octave_ff - 4'd1;
                  end
               end
            end
            state_in = ST_READ0;
         end

         // Fetch the most recent held button.
         ST_READ0: begin
            rd_idx    = KEY_W'(held_cnt_ff - 1'b1);
            v0_act_in = (held_cnt_ff != '0);
            v0_key_in = (held_cnt_ff != '0) ? rd_key : '0;
            state_in  = ST_READ1;
         end

         // Fetch the second most recent held button.
         ST_READ1: begin
            rd_idx    = KEY_W'(held_cnt_ff - CNT_W'(2));
            v1_act_in = (held_cnt_ff >= CNT_W'(2));
            v1_key_in = (held_cnt_ff >= CNT_W'(2)) ? rd_key : '0;
            state_in  = ST_EMIT;
         end

         // Load the response register once it is free.
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_v0_act_in  = v0_act_ff;
               out_v0_key_in  = 3'(v0_key_ff);
               out_v0_note_in = note_of(v0_key_ff);
               out_v1_act_in  = v1_act_ff;
               out_v1_key_in  = 3'(v1_key_ff);
               out_v1_note_in = note_of(v1_key_ff);
               out_octave_in  = octave_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         held_cnt_ff  <= '0;
         hist_cnt_ff  <= '0;
         octave_ff    <= OCTAVE_BASE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         held_cnt_ff  <= held_cnt_in;
         hist_cnt_ff  <= hist_cnt_in;
         octave_ff    <= octave_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      down_ff        <= down_in;
      edge_ff        <= edge_in;
      idx_ff         <= idx_in;
      wr_ff          <= wr_in;
      hist_ff        <= hist_in;
      v0_act_ff      <= v0_act_in;
      v0_key_ff      <= v0_key_in;
      v1_act_ff      <= v1_act_in;
      v1_key_ff      <= v1_key_in;
      out_v0_act_ff  <= out_v0_act_in;
      out_v0_key_ff  <= out_v0_key_in;
      out_v0_note_ff <= out_v0_note_in;
      out_v1_act_ff  <= out_v1_act_in;
      out_v1_key_ff  <= out_v1_key_in;
      out_v1_note_ff <= out_v1_note_in;
      out_octave_ff  <= out_octave_in;
      if (order_we) begin
         order_ff[order_wa] <= order_wd;
      end
   end

   // Port drive.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_voice0_active = out_v0_act_ff;
   assign rsp_voice0_key    = out_v0_key_ff;
   assign rsp_voice0_note   = out_v0_note_ff;
   assign rsp_voice1_active = out_v1_act_ff;
   assign rsp_voice1_key    = out_v1_key_ff;
   assign rsp_voice1_note   = out_v1_note_ff;
   assign rsp_octave_now    = out_octave_ff;

endmodule

@@ sv/tvka_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the two-voice key assigner, bound to the top level.
// Depends on tvka_pkg for the octave limits.

module tvka_port_checker
   import tvka_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_voice0_active,
   input logic [2:0] rsp_voice0_key,
   input logic [2:0] rsp_voice0_note,
   input logic       rsp_voice1_active,
   input logic [2:0] rsp_voice1_key,
   input logic [2:0] rsp_voice1_note,
   input logic [3:0] rsp_octave_now
);

   // The block is busy in the cycle after it takes a beat.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !reset) |=> req_stall)
      else $error("input not stalled after an accepted beat");

   // A stalled response beat holds its octave and voice keys.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_octave_now)
                                    && $stable(rsp_voice0_key) && $stable(rsp_voice1_key)))
      else $error("stalled response beat changed");

   // A second voice only sounds when the first one does.
   a_voice_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_voice1_active) |-> rsp_voice0_active)
      else $error("voice1 active without voice0");

   // The octave stays within its limits.
   a_octave_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_octave_now >= OCTAVE_MIN && rsp_octave_now <= OCTAVE_MAX))
      else $error("octave out of range");

   // Idle voices report a zero key and note.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_voice0_active || (rsp_voice0_key == 3'd0 && rsp_voice0_note == 3'd0))
                  && (rsp_voice1_active || (rsp_voice1_key == 3'd0 && rsp_voice1_note == 3'd0))))
      else $error("idle voice carries a key");

endmodule

bind two_voice_key_assigner_octave_gesture tvka_port_checker u_tvka_port_checker (.*);
